// ===== design/nbge_pkg.sv =====
`default_nettype none

package nbge_pkg;

   // Command codes carried by a request word.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAV  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;

   localparam logic [WORD_W-1:0]  GRAV_RESET  = 32'd65536;
   localparam logic [WORD_W-1:0]  DT_RESET    = 32'd6554;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

   // Shared multiplier and accumulator widths.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 132;

   typedef struct packed {
      logic                       cmd;
      logic [INDEX_W-1:0]         body_index;
      logic signed [WORD_W-1:0]   pos_x;
      logic signed [WORD_W-1:0]   pos_y;
      logic signed [WORD_W-1:0]   vel_x;
      logic signed [WORD_W-1:0]   vel_y;
      logic [WORD_W-1:0]          mass;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0]         out_index;
      logic signed [WORD_W-1:0]   new_pos_x;
      logic signed [WORD_W-1:0]   new_pos_y;
      logic signed [WORD_W-1:0]   new_vel_x;
      logic signed [WORD_W-1:0]   new_vel_y;
      logic                       coincident;
      logic [WORD_W-1:0]          steps_done;
      logic                       last;
   } rsp_word_type;

   // State of one body as it travels around the ring.
   typedef struct packed {
      logic signed [WORD_W-1:0]   x;
      logic signed [WORD_W-1:0]   y;
      logic signed [WORD_W-1:0]   vx;
      logic signed [WORD_W-1:0]   vy;
      logic [WORD_W-1:0]          mass;
      logic                       hit;
   } body_type;

   // Snapshot of a body's old position and mass for the pair sweep.
   typedef struct packed {
      logic signed [WORD_W-1:0]   x;
      logic signed [WORD_W-1:0]   y;
      logic [WORD_W-1:0]          mass;
   } vis_type;

   typedef struct packed {
      logic body_wr;
      logic body_shift;
      logic vis_copy;
      logic vis_shift;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      OP_GDT,
      OP_PAIR,
      OP_BODY
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_GDT,
      T_PAIR,
      T_PAIR_WAIT,
      T_BODY,
      T_BODY_WAIT,
      T_EMIT
   } top_state_type;

   typedef enum logic [3:0] {
      U_IDLE,
      U_GDT,
      U_DIFF,
      U_SQS,
      U_SQRT,
      U_R2,
      U_R3,
      U_GDM,
      U_NUMX,
      U_DIVX,
      U_NUMY,
      U_DIVY,
      U_BX,
      U_BY,
      U_BFIN
   } unit_state_type;

endpackage

`default_nettype wire

// ===== design/nbge_req_if.sv =====
`default_nettype none

interface nbge_req_if;
   import nbge_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/nbge_rsp_if.sv =====
`default_nettype none

interface nbge_rsp_if;
   import nbge_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/nbody_gravity_euler_step.sv =====
`default_nettype none

// Planar direct-sum gravity with explicit Euler steps in Q16.16. Bodies sit in
// a ring of MAX_BODIES cells; a load word writes one cell, and a step word
// rotates the ring past a shared pair unit and then streams one result word
// per active body, in slot order, with last on the final one. The
// request side is ready only while no step is in progress. A step first forms
// G*dt; then, for every ordered pair of distinct active bodies that do not
// coincide, the pair unit runs a square root, two restoring divides and the
// multiply passes, while a coincident pair only sets the hit flag; the step
// passes every other slot of the snapshot ring, updates each active body,
// passes each idle slot, and at the end emits the results.
module nbody_gravity_euler_step #(
   parameter int MAX_BODIES = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   nbge_req_if.sink                         req_port,
   nbge_rsp_if.source                       rsp_port,
   input  logic                             csr_wr_en,
   input  logic [nbge_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);
   import nbge_pkg::*;

   localparam int SW = $clog2(MAX_BODIES);
   localparam int NW = $clog2(MAX_BODIES + 1);
   localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

   top_state_type state_ff, state_in;
   logic [SW-1:0] i_ff, i_in;
   logic [SW-1:0] j_ff, j_in;
   logic [31:0]   step_ff, step_in;
   logic [31:0]   grav_ff, dt_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [CW-1:0] n_eff, i_ext;
   logic          i_act, j_act, i_last, j_last;
   logic          req_ready, rsp_valid;
   logic          load_en, body_shift, vis_shift, vis_copy, upd_wrap;
   unit_ctl_type  uctl;
   unit_sts_type  usts;
   body_type      unit_res, load_word;
   body_type      body_q [MAX_BODIES];
   vis_type       vis_q  [MAX_BODIES];

   // Active body count, clamped to one through MAX_BODIES.
   always_comb begin
      n_eff = CW'(count_ff);
      if (n_eff == '0) begin
         n_eff = CW'(1);
      end else if (n_eff > CW'(MAX_BODIES)) begin
         n_eff = CW'(MAX_BODIES);
      end
      i_ext  = CW'(i_ff);
      i_act  = (i_ext < n_eff);
      j_act  = (CW'(j_ff) < n_eff) && (j_ff != i_ff);
      i_last = (i_ff == SW'(MAX_BODIES - 1));
      j_last = (j_ff == SW'(MAX_BODIES - 1));
   end

   // Step sequencer: outer loop over bodies at cell zero, inner loop over
   // snapshots, then the result stream.
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      step_in    = step_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      load_en    = 1'b0;
      body_shift = 1'b0;
      vis_shift  = 1'b0;
      vis_copy   = 1'b0;
      upd_wrap   = 1'b0;
      uctl.start = 1'b0;
      uctl.op    = OP_GDT;
      unique case (state_ff)
         T_IDLE: begin
            req_ready = 1'b1;
            if (req_port.valid) begin
               if (req_port.data.cmd == CMD_STEP) begin
                  vis_copy   = 1'b1;
                  uctl.start = 1'b1;
                  uctl.op    = OP_GDT;
                  step_in    = step_ff + 32'd1;
                  i_in       = '0;
                  j_in       = '0;
                  state_in   = T_GDT;
               end else begin
                  load_en = 1'b1;
               end
            end
         end
         T_GDT: begin
            if (usts.done) begin
               state_in = T_PAIR;
            end
         end
         T_PAIR: begin
            if (!i_act) begin
               body_shift = 1'b1;
               if (i_last) begin
                  i_in     = '0;
                  state_in = T_EMIT;
               end else begin
                  i_in = i_ff + SW'(1);
               end
            end else if (j_act) begin
               uctl.start = 1'b1;
               uctl.op    = OP_PAIR;
               state_in   = T_PAIR_WAIT;
            end else begin
               vis_shift = 1'b1;
               if (j_last) begin
                  j_in     = '0;
                  state_in = T_BODY;
               end else begin
                  j_in = j_ff + SW'(1);
               end
            end
         end
         T_PAIR_WAIT: begin
            if (usts.done) begin
               vis_shift = 1'b1;
               if (j_last) begin
                  j_in     = '0;
                  state_in = T_BODY;
               end else begin
                  j_in     = j_ff + SW'(1);
                  state_in = T_PAIR;
               end
            end
         end
         T_BODY: begin
            uctl.start = 1'b1;
            uctl.op    = OP_BODY;
            state_in   = T_BODY_WAIT;
         end
         T_BODY_WAIT: begin
            if (usts.done) begin
               body_shift = 1'b1;
               upd_wrap   = 1'b1;
               if (i_last) begin
                  i_in     = '0;
                  state_in = T_EMIT;
               end else begin
                  i_in     = i_ff + SW'(1);
                  state_in = T_PAIR;
               end
            end
         end
         T_EMIT: begin
            rsp_valid = i_act;
            if (!i_act || rsp_port.ready) begin
               body_shift = 1'b1;
               if (i_last) begin
                  i_in     = '0;
                  state_in = T_IDLE;
               end else begin
                  i_in = i_ff + SW'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         step_ff  <= step_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff  <= GRAV_RESET;
         dt_ff    <= DT_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRAV:  grav_ff  <= csr_wdata;
            CSR_DT:    dt_ff    <= csr_wdata;
            CSR_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign load_word = '{x: req_port.data.pos_x, y: req_port.data.pos_y,
                        vx: req_port.data.vel_x, vy: req_port.data.vel_y,
                        mass: req_port.data.mass, hit: 1'b0};

   // Body ring: each cell takes its upper neighbor; the top cell takes cell
   // zero, or the updated body when one has just been finished.
   for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
      localparam int NXT = (k + 1) % MAX_BODIES;
      cell_ctl_type ctl;
      body_type     nxt;

      assign ctl.body_wr    = load_en &&
                              ({3'b000, req_port.data.body_index} == 7'(k));
      assign ctl.body_shift = body_shift;
      assign ctl.vis_copy   = vis_copy;
      assign ctl.vis_shift  = vis_shift;
      assign nxt = (k == MAX_BODIES - 1 && upd_wrap) ? unit_res : body_q[NXT];

      nbge_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .wr_data   (load_word),
         .body_next (nxt),
         .vis_next  (vis_q[NXT]),
         .body_q    (body_q[k]),
         .vis_q     (vis_q[k])
      );
   end

   nbge_pair_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_unit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (uctl),
      .body_i     (body_q[0]),
      .vis_j      (vis_q[0]),
      .grav_const (grav_ff),
      .time_step  (dt_ff),
      .sts        (usts),
      .result     (unit_res)
   );

   // Result word comes straight from cell zero while it is streamed out.
   assign req_port.ready             = req_ready;
   assign rsp_port.valid             = rsp_valid;
   assign rsp_port.data.out_index    = INDEX_W'(i_ff);
   assign rsp_port.data.new_pos_x    = body_q[0].x;
   assign rsp_port.data.new_pos_y    = body_q[0].y;
   assign rsp_port.data.new_vel_x    = body_q[0].vx;
   assign rsp_port.data.new_vel_y    = body_q[0].vy;
   assign rsp_port.data.coincident   = body_q[0].hit;
   assign rsp_port.data.steps_done   = step_ff;
   assign rsp_port.data.last         = ((i_ext + CW'(1)) == n_eff);

endmodule

`default_nettype wire

// ===== design/nbge_cell.sv =====
`default_nettype none

module nbge_cell (
   input  logic                   clock,
   input  nbge_pkg::cell_ctl_type ctl,
   input  nbge_pkg::body_type     wr_data,
   input  nbge_pkg::body_type     body_next,
   input  nbge_pkg::vis_type      vis_next,
   output nbge_pkg::body_type     body_q,
   output nbge_pkg::vis_type      vis_q
);
   import nbge_pkg::*;

   body_type body_ff, body_in;
   vis_type  vis_ff, vis_in;

   // A load writes the body; otherwise the ring moves one place on shift.
   // The snapshot ring copies the body in place or moves on its own.
   always_comb begin
      body_in = body_ff;
      if (ctl.body_wr) begin
         body_in = wr_data;
      end else if (ctl.body_shift) begin
         body_in = body_next;
      end
      vis_in = vis_ff;
      if (ctl.vis_copy) begin
         vis_in = '{x: body_ff.x, y: body_ff.y, mass: body_ff.mass};
      end else if (ctl.vis_shift) begin
         vis_in = vis_next;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
      vis_ff  <= vis_in;
   end

   assign body_q = body_ff;
   assign vis_q  = vis_ff;

endmodule

`default_nettype wire

// ===== design/nbge_pair_unit.sv =====
`default_nettype none

module nbge_pair_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nbge_pkg::unit_ctl_type ctl,
   input  nbge_pkg::body_type     body_i,
   input  nbge_pkg::vis_type      vis_j,
   input  logic [31:0]            grav_const,
   input  logic [31:0]            time_step,
   output nbge_pkg::unit_sts_type sts,
   output nbge_pkg::body_type     result
);
   import nbge_pkg::*;

   localparam logic [5:0] ITER_LAST = 6'd32;

   unit_state_type state_ff, state_in;
   logic [2:0]  mstep_ff, mstep_in;
   logic [5:0]  it_ff, it_in;
   logic        done_ff, done_in;
   logic        pend_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [1:0]  sh_ff;
   logic [ACC_W-1:0]  acc_ff;

   logic [63:0] gdt_ff;
   logic [32:0] mx_ff, my_ff;
   logic        negx_ff, negy_ff;
   logic [65:0] sq_ff;
   logic [33:0] srem_ff;
   logic [32:0] root_ff;
   logic [65:0] r2_ff;
   logic [98:0] den_ff;
   logic [96:0] gdm_ff;
   logic [ACC_W-1:0] rem_ff, dsh_ff;
   logic [32:0] q_ff;
   logic signed [37:0] ax_ff, ay_ff;
   logic        hit_ff;
   logic [63:0] mvx_ff, mvy_ff;
   body_type    res_ff;

   logic signed [32:0] dx, dy;
   logic [32:0] dx_mag, dy_mag;
   logic [31:0] vx_mag, vy_mag;
   logic [2:0]  mac_len;
   logic        mac_go, cap;
   logic [MUL_W-1:0] mac_a, mac_b;
   logic [1:0]  mac_sh;
   logic [35:0] s_cat, s_trial;
   logic        s_ge;
   logic        d_ge;
   logic [32:0] q_next, term;
   logic signed [37:0] term_s;
   logic signed [65:0] px_w, py_w, nvx_w, nvy_w;
   logic signed [65:0] dpx_s, dpy_s;

   function automatic logic [31:0] sat66(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Pair offsets and magnitudes from the old positions.
   always_comb begin
      dx = $signed({vis_j.x[31], vis_j.x}) - $signed({body_i.x[31], body_i.x});
      dy = $signed({vis_j.y[31], vis_j.y}) - $signed({body_i.y[31], body_i.y});
      dx_mag = dx[32] ? -dx : dx;
      dy_mag = dy[32] ? -dy : dy;
      vx_mag = body_i.vx[31] ? -body_i.vx : body_i.vx;
      vy_mag = body_i.vy[31] ? -body_i.vy : body_i.vy;
   end

   // Operand selection for the shared multiplier: one partial product a cycle.
   always_comb begin
      mac_a = '0;
      mac_b = '0;
      mac_sh = mstep_ff[1:0];
      mac_len = 3'd0;
      case (state_ff)
         U_GDT: begin
            mac_len = 3'd1;
            mac_a = {1'b0, grav_const};
            mac_b = {1'b0, time_step};
         end
         U_SQS: begin
            mac_len = 3'd2;
            mac_sh = 2'd0;
            mac_a = (mstep_ff == 3'd0) ? mx_ff : my_ff;
            mac_b = (mstep_ff == 3'd0) ? mx_ff : my_ff;
         end
         U_R2: begin
            mac_len = 3'd1;
            mac_a = root_ff;
            mac_b = root_ff;
         end
         U_R3: begin
            mac_len = 3'd2;
            mac_a = (mstep_ff == 3'd0) ? r2_ff[32:0] : r2_ff[65:33];
            mac_b = root_ff;
         end
         U_GDM: begin
            mac_len = 3'd2;
            mac_a = (mstep_ff == 3'd0) ? gdt_ff[32:0] : {2'b00, gdt_ff[63:33]};
            mac_b = {1'b0, vis_j.mass};
         end
         U_NUMX, U_NUMY: begin
            mac_len = 3'd3;
            case (mstep_ff)
               3'd0:    mac_a = gdm_ff[32:0];
               3'd1:    mac_a = gdm_ff[65:33];
               default: mac_a = {2'b00, gdm_ff[96:66]};
            endcase
            mac_b = (state_ff == U_NUMX) ? mx_ff : my_ff;
         end
         U_BX: begin
            mac_len = 3'd1;
            mac_a = {1'b0, vx_mag};
            mac_b = {1'b0, time_step};
         end
         U_BY: begin
            mac_len = 3'd1;
            mac_a = {1'b0, vy_mag};
            mac_b = {1'b0, time_step};
         end
         default: begin
            mac_len = 3'd0;
         end
      endcase
      mac_go = (mstep_ff < mac_len);
      cap = (mac_len != 3'd0) && (mstep_ff == mac_len + 3'd1);
   end

   // One square root digit and one quotient bit per cycle.
   always_comb begin
      s_cat   = {srem_ff, sq_ff[65:64]};
      s_trial = {1'b0, root_ff, 2'b01};
      s_ge    = (s_cat >= s_trial);
      d_ge    = (rem_ff >= dsh_ff);
      q_next  = {q_ff[31:0], d_ge};
      term    = q_next[32] ? 33'h1_0000_0000 : q_next;
      if ((state_ff == U_DIVX) ? negx_ff : negy_ff) begin
         term_s = -$signed({5'b00000, term});
      end else begin
         term_s = $signed({5'b00000, term});
      end
   end

   // Final Euler update of one body.
   always_comb begin
      dpx_s = $signed({2'b00, 64'(mvx_ff >> FRAC_BITS)});
      dpy_s = $signed({2'b00, 64'(mvy_ff >> FRAC_BITS)});
      px_w  = $signed({{34{body_i.x[31]}}, body_i.x})
            + (body_i.vx[31] ? -dpx_s : dpx_s);
      py_w  = $signed({{34{body_i.y[31]}}, body_i.y})
            + (body_i.vy[31] ? -dpy_s : dpy_s);
      nvx_w = $signed({{34{body_i.vx[31]}}, body_i.vx})
            + $signed({{28{ax_ff[37]}}, ax_ff});
      nvy_w = $signed({{34{body_i.vy[31]}}, body_i.vy})
            + $signed({{28{ay_ff[37]}}, ay_ff});
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      it_in    = it_ff;
      done_in  = 1'b0;
      mstep_in = 3'd0;
      if (mac_len != 3'd0 && !cap) begin
         mstep_in = mstep_ff + 3'd1;
      end
      unique case (state_ff)
         U_IDLE: begin
            if (ctl.start) begin
               unique case (ctl.op)
                  OP_GDT:  state_in = U_GDT;
                  OP_PAIR: state_in = U_DIFF;
                  OP_BODY: state_in = U_BX;
                  default: state_in = U_IDLE;
               endcase
            end
         end
         U_GDT: begin
            if (cap) begin
               state_in = U_IDLE;
               done_in  = 1'b1;
            end
         end
         U_DIFF: begin
            if (dx == 33'sd0 && dy == 33'sd0) begin
               state_in = U_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = U_SQS;
            end
         end
         U_SQS: begin
            if (cap) begin
               state_in = U_SQRT;
               it_in    = 6'd0;
            end
         end
         U_SQRT: begin
            it_in = it_ff + 6'd1;
            if (it_ff == ITER_LAST) begin
               state_in = U_R2;
            end
         end
         U_R2:   if (cap) state_in = U_R3;
         U_R3:   if (cap) state_in = U_GDM;
         U_GDM:  if (cap) state_in = U_NUMX;
         U_NUMX: begin
            if (cap) begin
               state_in = U_DIVX;
               it_in    = 6'd0;
            end
         end
         U_DIVX: begin
            it_in = it_ff + 6'd1;
            if (it_ff == ITER_LAST) begin
               state_in = U_NUMY;
            end
         end
         U_NUMY: begin
            if (cap) begin
               state_in = U_DIVY;
               it_in    = 6'd0;
            end
         end
         U_DIVY: begin
            it_in = it_ff + 6'd1;
            if (it_ff == ITER_LAST) begin
               state_in = U_IDLE;
               done_in  = 1'b1;
            end
         end
         U_BX:   if (cap) state_in = U_BY;
         U_BY:   if (cap) state_in = U_BFIN;
         U_BFIN: begin
            state_in = U_IDLE;
            done_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         mstep_ff <= 3'd0;
         it_ff    <= 6'd0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         it_ff    <= it_in;
         done_ff  <= done_in;
         pend_ff  <= mac_go;
      end
   end

   // Multiply stage, then shifted accumulate in the next cycle.
   always_ff @(posedge clock) begin
      prod_ff <= mac_a * mac_b;
      sh_ff   <= mac_sh;
      if (state_ff == U_IDLE || cap) begin
         acc_ff <= '0;
      end else if (pend_ff) begin
         acc_ff <= acc_ff + ({66'd0, prod_ff} << (7'd33 * {5'd0, sh_ff}));
      end
   end

   // Datapath registers of the pair and body sequences.
   always_ff @(posedge clock) begin
      case (state_ff)
         U_GDT: begin
            if (cap) begin
               gdt_ff <= acc_ff[63:0];
               ax_ff  <= '0;
               ay_ff  <= '0;
               hit_ff <= 1'b0;
            end
         end
         U_DIFF: begin
            mx_ff   <= dx_mag;
            my_ff   <= dy_mag;
            negx_ff <= dx[32];
            negy_ff <= dy[32];
            if (dx == 33'sd0 && dy == 33'sd0) begin
               hit_ff <= 1'b1;
            end
         end
         U_SQS: begin
            if (cap) begin
               sq_ff   <= acc_ff[65:0];
               srem_ff <= '0;
               root_ff <= '0;
            end
         end
         U_SQRT: begin
            sq_ff   <= {sq_ff[63:0], 2'b00};
            srem_ff <= s_ge ? 34'(s_cat - s_trial) : s_cat[33:0];
            root_ff <= {root_ff[31:0], s_ge};
         end
         U_R2: if (cap) r2_ff <= acc_ff[65:0];
         U_R3: if (cap) den_ff <= acc_ff[98:0];
         U_GDM: if (cap) gdm_ff <= acc_ff[96:0];
         U_NUMX, U_NUMY: begin
            if (cap) begin
               rem_ff <= acc_ff;
               dsh_ff <= {1'b0, den_ff, 32'd0};
               q_ff   <= '0;
            end
         end
         U_DIVX, U_DIVY: begin
            if (d_ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            dsh_ff <= dsh_ff >> 1;
            q_ff   <= q_next;
            if (it_ff == ITER_LAST) begin
               if (state_ff == U_DIVX) begin
                  ax_ff <= ax_ff + term_s;
               end else begin
                  ay_ff <= ay_ff + term_s;
               end
            end
         end
         U_BX: if (cap) mvx_ff <= acc_ff[63:0];
         U_BY: if (cap) mvy_ff <= acc_ff[63:0];
         U_BFIN: begin
            res_ff.x    <= sat66(px_w);
            res_ff.y    <= sat66(py_w);
            res_ff.vx   <= sat66(nvx_w);
            res_ff.vy   <= sat66(nvy_w);
            res_ff.mass <= body_i.mass;
            res_ff.hit  <= hit_ff;
            ax_ff  <= '0;
            ay_ff  <= '0;
            hit_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign sts.done = done_ff;
   assign result   = res_ff;

endmodule

`default_nettype wire
